[rtl/local_mean_sidereal_time_assert.svh]
// Assertion macros for the local mean sidereal time block.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef LOCAL_MEAN_SIDEREAL_TIME_ASSERT_SVH
`define LOCAL_MEAN_SIDEREAL_TIME_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LMST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lmst assertion failed");

// next-cycle implication, disabled while in reset
`define LMST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lmst assertion failed");

`endif

[rtl/lmst_pkg.sv]
// Shared widths, fixed-point constants and the inter-stage struct.
// No dependencies; used by lmst_split, lmst_poly and the top level.
package lmst_pkg;

    localparam int TIME_W   = 40;
    localparam int ZONE_W   = 5;
    localparam int LON_W    = 32;
    localparam int ACC_W    = 64;

    // universal time biased by one day so it is never negative
    localparam int UT_W     = 41;
    localparam int BIAS_W   = 18;
    localparam int UT_BIAS  = 86400;
    localparam int ZONE_SEC = 3600;

    // seconds per day = 675 * 2^7
    localparam int DAY_SH   = 7;
    localparam int DAY_ODD  = 675;
    localparam int DAYQ_W   = UT_W - DAY_SH;
    localparam int RECIP_SH = 34;
    localparam int RECIP_W  = 25;
    localparam logic [RECIP_W-1:0] DAY_RECIP =
        RECIP_W'((64'd1 << RECIP_SH) / 64'd675);
    localparam int REM_W    = 11;
    localparam int LOW_W    = DAY_SH + REM_W;
    localparam int QD_W     = 24;
    localparam int SEC_W    = 17;

    // half-days from J2000
    localparam int D2_W     = 26;
    localparam int D2_OFS   = 21917;
    localparam int M_W      = 25;

    // centuries in Q32: floor(m * 2^32 / 73050)
    localparam int HC       = 73050;
    localparam int TQ_SH    = 25;
    localparam int KQ_W     = 41;
    localparam logic [KQ_W-1:0] KQ = KQ_W'((128'd1 << 57) / 128'd73050);
    localparam int TQ_W     = 41;
    localparam int TQ_REM_W = 18;
    localparam int T2_W     = 50;
    localparam int T3_W     = 59;
    localparam int QUAD_W   = 62;
    localparam int CUBE_W   = 58;
    localparam int Q32_SH   = 32;

    // Q0.64 coefficients in turns
    localparam int K1_W = 55;
    localparam int K2_W = 45;
    localparam int K3_W = 31;
    localparam int KS_W = 48;
    localparam logic [ACC_W-1:0] K0 =
        ACC_W'((128'd10046061837 << 64) / 128'd36000000000);
    localparam logic [K1_W-1:0] K1 =
        K1_W'((128'd36000770053608 << 64) / 128'd26298000000000000);
    localparam logic [K2_W-1:0] K2 =
        K2_W'((128'd387933 << 64) / 128'd360000000000);
    localparam logic [K3_W-1:0] K3 =
        K3_W'((128'd1 << 64) / 128'd13935600000);
    localparam logic [KS_W-1:0] KS =
        KS_W'((128'd100273790935 << 64) / 128'd8640000000000000);

    localparam int SPLIT_LAT = 6;
    localparam int PIPE_LAT  = 17;

    typedef struct packed {
        logic [M_W-1:0]   m;
        logic             neg;
        logic [SEC_W-1:0] sec;
        logic [LON_W-1:0] lon;
    } t_split;

endpackage

[rtl/lmst_mul_shr.sv]
// Two-stage split multiplier: four registered partial products, then
// a registered sum returning floor(a * b / 2^SH) truncated to OW bits. No deps.
module lmst_mul_shr #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int SH = 32,
    parameter int OW = 32
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_a,
    input  logic [BW-1:0] i_b,
    output logic [OW-1:0] o_p
);

    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AH+BH-1:0] r_hh;
    logic [AH+BL-1:0] r_hl;
    logic [AL+BH-1:0] r_lh;
    logic [AL+BL-1:0] r_ll;
    logic [PW-1:0]    n_sum;
    logic [OW-1:0]    r_p;

    always_ff @(posedge i_clk) begin
        r_hh <= i_a[AW-1:AL] * i_b[BW-1:BL];
        r_hl <= i_a[AW-1:AL] * i_b[BL-1:0];
        r_lh <= i_a[AL-1:0] * i_b[BW-1:BL];
        r_ll <= i_a[AL-1:0] * i_b[BL-1:0];
        r_p  <= n_sum[SH +: OW];
    end

    always_comb begin
        n_sum = (PW'(r_hh) << (AL + BL)) + (PW'(r_hl) << AL)
              + (PW'(r_lh) << BL) + PW'(r_ll);
    end

    assign o_p = r_p;

endmodule

[rtl/lmst_split.sv]
// Front stages: universal time, day/second split by reciprocal multiply,
// half-day count from J2000 and its magnitude. Uses lmst_pkg, lmst_mul_shr.
module lmst_split
    import lmst_pkg::*;
(
    input  logic                     i_clk,
    input  logic [TIME_W-1:0]        i_unix_time,
    input  logic signed [ZONE_W-1:0] i_zone_hours,
    input  logic [LON_W-1:0]         i_longitude,
    output t_split                   o_split
);

    logic [BIAS_W-1:0]   n_bias;
    logic [UT_W-1:0]     n_ut;
    logic [UT_W-1:0]     r_s1_ut;
    logic [LOW_W-1:0]    r_s2_low;
    logic [LOW_W-1:0]    r_s3_low;
    logic [LOW_W-1:0]    r_s4_low;
    logic [QD_W-1:0]     w_qe;
    logic [QD_W-1:0]     r_s4_qe;
    logic [REM_W-1:0]    r_s4_prod;
    logic [REM_W-1:0]    n_rem;
    logic [REM_W-1:0]    n_rem_fix;
    logic                n_fix;
    logic [QD_W-1:0]     r_s5_qd;
    logic [SEC_W-1:0]    r_s5_sec;
    logic signed [D2_W-1:0] n_d2;
    logic [M_W-1:0]      n_m;
    logic [M_W-1:0]      r_s6_m;
    logic                r_s6_neg;
    logic [SEC_W-1:0]    r_s6_sec;
    logic [LON_W-1:0]    r_lon [SPLIT_LAT];

    always_comb begin
        n_bias = BIAS_W'(UT_BIAS + ZONE_SEC * int'(i_zone_hours));
        n_ut   = UT_W'(i_unix_time) + UT_W'(n_bias);
    end

    // day estimate, low by at most one
    lmst_mul_shr #(
        .AW (DAYQ_W),
        .BW (RECIP_W),
        .SH (RECIP_SH),
        .OW (QD_W)
    ) u_day_div (
        .i_clk (i_clk),
        .i_a   (r_s1_ut[UT_W-1:DAY_SH]),
        .i_b   (DAY_RECIP),
        .o_p   (w_qe)
    );

    always_comb begin
        n_rem     = r_s4_low[LOW_W-1:DAY_SH] - r_s4_prod;
        n_fix     = (n_rem >= REM_W'(DAY_ODD));
        n_rem_fix = n_fix ? (n_rem - REM_W'(DAY_ODD)) : n_rem;
        n_d2      = $signed({1'b0, r_s5_qd, 1'b0}) - D2_W'(D2_OFS);
        n_m       = n_d2[D2_W-1] ? M_W'(-n_d2) : M_W'(n_d2);
    end

    always_ff @(posedge i_clk) begin
        r_s1_ut   <= n_ut;
        r_s2_low  <= r_s1_ut[LOW_W-1:0];
        r_s3_low  <= r_s2_low;
        r_s4_low  <= r_s3_low;
        r_s4_qe   <= w_qe;
        r_s4_prod <= w_qe[REM_W-1:0] * REM_W'(DAY_ODD);
        r_s5_qd   <= r_s4_qe + QD_W'(n_fix);
        r_s5_sec  <= {n_rem_fix[SEC_W-DAY_SH-1:0], r_s4_low[DAY_SH-1:0]};
        r_s6_m    <= n_m;
        r_s6_neg  <= n_d2[D2_W-1];
        r_s6_sec  <= r_s5_sec;
        r_lon[0]  <= i_longitude;
        for (int i = 1; i < SPLIT_LAT; i++) begin
            r_lon[i] <= r_lon[i-1];
        end
    end

    always_comb begin
        o_split.m   = r_s6_m;
        o_split.neg = r_s6_neg;
        o_split.sec = r_s6_sec;
        o_split.lon = r_lon[SPLIT_LAT-1];
    end

endmodule

[rtl/lmst_poly.sv]
// Back stages: centuries in Q32, square and cube, coefficient products,
// linear and time-of-day terms, final accumulate. Uses lmst_pkg, lmst_mul_shr.
module lmst_poly
    import lmst_pkg::*;
#(
    parameter int ANGLE_BITS = 32
) (
    input  logic                  i_clk,
    input  t_split                i_split,
    output logic [ANGLE_BITS-1:0] o_angle
);

    localparam int NEG_DLY  = 10;
    localparam int BASE_DLY = 4;

    logic [TQ_W-1:0]       w_tqe;
    logic [ACC_W-1:0]      w_lin;
    logic [ACC_W-1:0]      w_day;
    logic [LON_W-1:0]      r_s7_lon;
    logic [LON_W-1:0]      r_s8_lon;
    logic                  r_neg [NEG_DLY];
    logic [TQ_W-1:0]       r_s9_tqe;
    logic [TQ_REM_W-1:0]   r_s9_prod;
    logic [ACC_W-1:0]      r_s9_lt;
    logic [ACC_W-1:0]      r_s9_dt;
    logic [TQ_REM_W-1:0]   n_trem;
    logic [TQ_W-1:0]       r_s10_tq;
    logic [ACC_W-1:0]      r_s10_base;
    logic [TQ_W-1:0]       r_s11_tq;
    logic [TQ_W-1:0]       r_s12_tq;
    logic [ACC_W-1:0]      r_base [BASE_DLY];
    logic [T2_W-1:0]       w_t2;
    logic [T3_W-1:0]       w_t3;
    logic [QUAD_W-1:0]     w_quad;
    logic [CUBE_W-1:0]     w_cube;
    logic [ACC_W-1:0]      r_s15_bq;
    logic [ACC_W-1:0]      r_s16_bq;
    logic [ACC_W-1:0]      n_acc;
    logic [ANGLE_BITS-1:0] r_s17_angle;

    lmst_mul_shr #(.AW(M_W), .BW(KQ_W), .SH(TQ_SH), .OW(TQ_W)) u_tq (
        .i_clk (i_clk),
        .i_a   (i_split.m),
        .i_b   (KQ),
        .o_p   (w_tqe)
    );

    lmst_mul_shr #(.AW(M_W), .BW(K1_W), .SH(0), .OW(ACC_W)) u_lin (
        .i_clk (i_clk),
        .i_a   (i_split.m),
        .i_b   (K1),
        .o_p   (w_lin)
    );

    lmst_mul_shr #(.AW(SEC_W), .BW(KS_W), .SH(0), .OW(ACC_W)) u_tod (
        .i_clk (i_clk),
        .i_a   (i_split.sec),
        .i_b   (KS),
        .o_p   (w_day)
    );

    lmst_mul_shr #(.AW(TQ_W), .BW(TQ_W), .SH(Q32_SH), .OW(T2_W)) u_sq (
        .i_clk (i_clk),
        .i_a   (r_s10_tq),
        .i_b   (r_s10_tq),
        .o_p   (w_t2)
    );

    lmst_mul_shr #(.AW(T2_W), .BW(TQ_W), .SH(Q32_SH), .OW(T3_W)) u_cb (
        .i_clk (i_clk),
        .i_a   (w_t2),
        .i_b   (r_s12_tq),
        .o_p   (w_t3)
    );

    lmst_mul_shr #(.AW(T2_W), .BW(K2_W), .SH(Q32_SH), .OW(QUAD_W)) u_quad (
        .i_clk (i_clk),
        .i_a   (w_t2),
        .i_b   (K2),
        .o_p   (w_quad)
    );

    lmst_mul_shr #(.AW(T3_W), .BW(K3_W), .SH(Q32_SH), .OW(CUBE_W)) u_cube (
        .i_clk (i_clk),
        .i_a   (w_t3),
        .i_b   (K3),
        .o_p   (w_cube)
    );

    always_comb begin
        // low bits of m * 2^32 - tqe * 73050 are those of -(tqe * 73050)
        n_trem = TQ_REM_W'(0) - r_s9_prod;
        n_acc  = r_neg[NEG_DLY-1] ? (r_s16_bq + ACC_W'(w_cube))
                                  : (r_s16_bq - ACC_W'(w_cube));
    end

    always_ff @(posedge i_clk) begin
        r_s7_lon  <= i_split.lon;
        r_s8_lon  <= r_s7_lon;
        r_neg[0]  <= i_split.neg;
        for (int i = 1; i < NEG_DLY; i++) begin
            r_neg[i] <= r_neg[i-1];
        end

        r_s9_tqe  <= w_tqe;
        r_s9_prod <= w_tqe[TQ_REM_W-1:0] * TQ_REM_W'(HC);
        r_s9_lt   <= r_neg[1] ? (K0 - w_lin) : (K0 + w_lin);
        r_s9_dt   <= w_day - {r_s8_lon, {(ACC_W-LON_W){1'b0}}};

        r_s10_tq   <= r_s9_tqe + TQ_W'(n_trem >= TQ_REM_W'(HC));
        r_s10_base <= r_s9_lt + r_s9_dt;
        r_s11_tq   <= r_s10_tq;
        r_s12_tq   <= r_s11_tq;

        r_base[0] <= r_s10_base;
        for (int i = 1; i < BASE_DLY; i++) begin
            r_base[i] <= r_base[i-1];
        end

        r_s15_bq    <= r_base[BASE_DLY-1] + ACC_W'(w_quad);
        r_s16_bq    <= r_s15_bq;
        r_s17_angle <= n_acc[ACC_W-1 -: ANGLE_BITS];
    end

    assign o_angle = r_s17_angle;

endmodule

[rtl/local_mean_sidereal_time.sv]
// Throughput: one item per cycle unless busy; most products use two-stage split units.
// The chain of reciprocal day split, centuries, square, cube, cubic term sets latency.
// Reset (sync, active low) clears the valid pipeline; busy is high during reset
// and in the cycle after. Results carry a one-cycle strobe, no backpressure.
`include "local_mean_sidereal_time_assert.svh"

module local_mean_sidereal_time
    import lmst_pkg::*;
#(
    parameter int ANGLE_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [TIME_W-1:0]        i_unix_time,
    input  logic signed [ZONE_W-1:0] i_zone_hours,
    input  logic signed [LON_W-1:0]  i_longitude,
    output logic                     o_valid,
    output logic [ANGLE_BITS-1:0]    o_sidereal_angle
);

    logic                r_busy;
    logic [PIPE_LAT-1:0] r_vld;
    logic [PIPE_LAT-1:0] n_vld;
    logic                n_accept;
    t_split              w_split;

    assign n_accept = start && !r_busy;
    assign n_vld    = {r_vld[PIPE_LAT-2:0], n_accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= n_vld;
        end
    end

    lmst_split u_split (
        .i_clk        (i_clk),
        .i_unix_time  (i_unix_time),
        .i_zone_hours (i_zone_hours),
        .i_longitude  (i_longitude),
        .o_split      (w_split)
    );

    lmst_poly #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_poly (
        .i_clk   (i_clk),
        .i_split (w_split),
        .o_angle (o_sidereal_angle)
    );

    assign busy    = r_busy;
    assign o_valid = r_vld[PIPE_LAT-1];

    `LMST_ASSERT_IMP(a_lat, 1'b1, o_valid == ($past(start && !busy, PIPE_LAT) === 1'b1))
    `LMST_ASSERT_NEXT(a_busy_stays_low, !busy, !busy)
    `LMST_ASSERT_IMP(a_same_in_same_out,
        o_valid && $past(o_valid)
            && ($past(i_unix_time, PIPE_LAT) == $past(i_unix_time, PIPE_LAT + 1))
            && ($past(i_zone_hours, PIPE_LAT) == $past(i_zone_hours, PIPE_LAT + 1))
            && ($past(i_longitude, PIPE_LAT) == $past(i_longitude, PIPE_LAT + 1)),
        $stable(o_sidereal_angle))

endmodule
